// File: src/mavg_pkg.sv
// ----------------------------------------------------------------------------
// mavg_pkg
// shared constants and register codes for the moving average filter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mavg_pkg;

  // build-time defaults
  localparam int MAX_WINDOW_DEF  = 64;
  localparam int SAMPLE_BITS_DEF = 16;

  // window length register
  localparam int            WL_W     = 7;
  localparam logic [WL_W-1:0] WL_RESET = 7'd8;

  // configuration register index
  localparam int CFG_IDX_W = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW_LENGTH = 1'b0,
    REG_INIT_VALUE    = 1'b1
  } cfg_reg_e;

endpackage : mavg_pkg

`default_nettype wire

// File: src/mavg_front.sv
// ----------------------------------------------------------------------------
// mavg_front
// config registers, history ring read-modify-write and running sum
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mavg_front
  import mavg_pkg::*;
#(
  parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  localparam int PTR_W      = $clog2(MAX_WINDOW),
  localparam int LEN_W      = $clog2(MAX_WINDOW + 1),
  localparam int SUM_W      = SAMPLE_BITS + $clog2(MAX_WINDOW)
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           cfg_we_i,
  input  wire  [CFG_IDX_W-1:0]          cfg_index_i,
  input  wire  [SAMPLE_BITS-1:0]        cfg_wdata_i,
  input  wire                           in_valid_i,
  output logic                          in_ready_o,
  input  wire  signed [SAMPLE_BITS-1:0] sample_i,
  input  wire                           adv_i,
  output logic                          div_valid_o,
  output logic signed [SUM_W-1:0]       div_sum_o,
  output logic [LEN_W-1:0]              div_len_o
);

  localparam int CMP_W = (WL_W > LEN_W) ? WL_W : LEN_W;
  localparam int EXT_W = PTR_W + 1;

  // configuration
  logic [WL_W-1:0]               wl_q;
  logic signed [SAMPLE_BITS-1:0] init_q;
  logic                          pend_q;

  // ring state
  logic [SAMPLE_BITS-1:0]        hist_mem [MAX_WINDOW];
  logic [SAMPLE_BITS-1:0]        rd_q;
  logic [PTR_W-1:0]              wp_q;
  logic [LEN_W-1:0]              fill_q;
  logic signed [SUM_W-1:0]       sum_q;

  // pipeline
  logic                          s1_valid_q;
  logic signed [SAMPLE_BITS-1:0] s1_sample_q;
  logic                          s1_fresh_q;
  logic                          s2_valid_q;

  logic [LEN_W-1:0]              eff_len;
  logic [CMP_W-1:0]              wl_ext;
  logic [EXT_W-1:0]              old_ext;
  logic [PTR_W-1:0]              oldest;
  logic                          fresh;
  logic                          acc;
  logic signed [SAMPLE_BITS-1:0] old_val;
  logic signed [SUM_W-1:0]       sum_next;
  logic signed [LEN_W+SAMPLE_BITS:0] preload_prod;

  // zero means one, above the ring depth saturates
  assign wl_ext = CMP_W'(wl_q);

  always_comb begin
    if (wl_q == '0) begin
      eff_len = LEN_W'(1);
    end else if (wl_ext > CMP_W'(MAX_WINDOW)) begin
      eff_len = LEN_W'(MAX_WINDOW);
    end else begin
      eff_len = LEN_W'(wl_q);
    end
  end

  // slot leaving the window, modulo ring depth
  assign old_ext = EXT_W'(wp_q) + EXT_W'(MAX_WINDOW) - EXT_W'(eff_len);

  always_comb begin
    if (old_ext >= EXT_W'(MAX_WINDOW)) begin
      oldest = PTR_W'(old_ext - EXT_W'(MAX_WINDOW));
    end else begin
      oldest = PTR_W'(old_ext);
    end
  end

  // slots at or past the fill count still hold the preload value
  assign fresh = (fill_q == LEN_W'(MAX_WINDOW)) || (LEN_W'(oldest) < fill_q);

  assign in_ready_o = !pend_q && (!s1_valid_q || adv_i);
  assign acc        = in_valid_i && in_ready_o;

  assign old_val  = s1_fresh_q ? $signed(rd_q) : init_q;
  assign sum_next = sum_q - SUM_W'(old_val) + SUM_W'(s1_sample_q);

  assign preload_prod = $signed({1'b0, eff_len}) * init_q;

  // history ring, read of the leaving slot sees the value before this write
  always_ff @(posedge clk_i) begin
    if (acc) begin
      hist_mem[wp_q] <= sample_i;
      rd_q           <= hist_mem[oldest];
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      s1_sample_q <= sample_i;
      s1_fresh_q  <= fresh;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wl_q       <= WL_RESET;
      init_q     <= '0;
      pend_q     <= 1'b0;
      wp_q       <= '0;
      fill_q     <= '0;
      sum_q      <= '0;
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (acc) begin
        wp_q <= (wp_q == PTR_W'(MAX_WINDOW - 1)) ? '0 : wp_q + 1'b1;
        if (fill_q != LEN_W'(MAX_WINDOW)) begin
          fill_q <= fill_q + 1'b1;
        end
      end

      if (acc) begin
        s1_valid_q <= 1'b1;
      end else if (adv_i) begin
        s1_valid_q <= 1'b0;
      end

      if (adv_i) begin
        s2_valid_q <= s1_valid_q;
      end

      if (pend_q) begin
        sum_q  <= SUM_W'(preload_prod);
        pend_q <= 1'b0;
      end else if (adv_i && s1_valid_q) begin
        sum_q <= sum_next;
      end

      // user writes only while idle, not enforced; preload restarts ring
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_WINDOW_LENGTH: begin
            wl_q   <= cfg_wdata_i[WL_W-1:0];
            pend_q <= 1'b1;
            wp_q   <= '0;
            fill_q <= '0;
          end
          REG_INIT_VALUE: begin
            init_q <= cfg_wdata_i;
            pend_q <= 1'b1;
            wp_q   <= '0;
            fill_q <= '0;
          end
          default: begin
          end
        endcase
      end
    end
  end

  assign div_valid_o = s2_valid_q;
  assign div_sum_o   = sum_q;
  assign div_len_o   = eff_len;

  // until the ring wraps, the write slot tracks the fill count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q != LEN_W'(MAX_WINDOW)) |-> (LEN_W'(wp_q) == fill_q))
    else $error("write pointer out of step with fill count");

  // a held sum stage keeps its sum
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_valid_q && !adv_i && !pend_q && !cfg_we_i) |=> $stable(sum_q))
    else $error("running sum moved under a stalled beat");

  // preload lasts a single cycle and blocks new beats
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_q && !cfg_we_i) |=> !pend_q)
    else $error("preload did not complete");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> !acc)
    else $error("beat accepted during preload");

endmodule : mavg_front

`default_nettype wire

// File: src/mavg_div.sv
// ----------------------------------------------------------------------------
// mavg_div
// pipelined restoring divider, one quotient bit per stage, output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mavg_div
  import mavg_pkg::*;
#(
  parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  localparam int LEN_W      = $clog2(MAX_WINDOW + 1),
  localparam int SUM_W      = SAMPLE_BITS + $clog2(MAX_WINDOW)
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           div_valid_i,
  input  wire  signed [SUM_W-1:0]       div_sum_i,
  input  wire  [LEN_W-1:0]              div_len_i,
  output logic                          adv_o,
  output logic                          out_valid_o,
  input  wire                           out_ready_i,
  output logic signed [SAMPLE_BITS-1:0] average_o
);

  logic             v_in   [SUM_W];
  logic [SUM_W-1:0] n_in   [SUM_W];
  logic [LEN_W-1:0] r_in   [SUM_W];
  logic [LEN_W-1:0] d_in   [SUM_W];
  logic             neg_in [SUM_W];

  logic             v_q    [SUM_W];
  logic [SUM_W-1:0] nq_q   [SUM_W];
  logic [LEN_W-1:0] r_q    [SUM_W];
  logic [LEN_W-1:0] d_q    [SUM_W];
  logic             neg_q  [SUM_W];

  logic             out_valid_q;
  logic [SAMPLE_BITS-1:0] avg_q;
  logic [SUM_W-1:0] mag;
  logic [SUM_W-1:0] q_fin;
  logic [SUM_W-1:0] q_signed;

  // whole pipe moves unless a finished beat waits at the output
  assign adv_o = !out_valid_q || out_ready_i;

  assign mag = div_sum_i[SUM_W-1] ? SUM_W'(-div_sum_i) : SUM_W'(div_sum_i);

  for (genvar k = 0; k < SUM_W; k++) begin : g_stage
    logic [LEN_W:0]   trial;
    logic [LEN_W:0]   diff;
    logic             ge;
    logic [LEN_W-1:0] r_nx;
    logic [SUM_W-1:0] nq_nx;

    if (k == 0) begin : g_head
      assign v_in[k]   = div_valid_i;
      assign n_in[k]   = mag;
      assign r_in[k]   = '0;
      assign d_in[k]   = div_len_i;
      assign neg_in[k] = div_sum_i[SUM_W-1];
    end else begin : g_body
      assign v_in[k]   = v_q[k-1];
      assign n_in[k]   = nq_q[k-1];
      assign r_in[k]   = r_q[k-1];
      assign d_in[k]   = d_q[k-1];
      assign neg_in[k] = neg_q[k-1];
    end

    // shift in the next dividend bit, subtract when it fits
    assign trial = {r_in[k], n_in[k][SUM_W-1]};
    assign diff  = trial - {1'b0, d_in[k]};
    assign ge    = trial >= {1'b0, d_in[k]};
    assign r_nx  = ge ? diff[LEN_W-1:0] : trial[LEN_W-1:0];
    assign nq_nx = {n_in[k][SUM_W-2:0], ge};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (adv_o) begin
        v_q[k] <= v_in[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_o) begin
        nq_q[k]  <= nq_nx;
        r_q[k]   <= r_nx;
        d_q[k]   <= d_in[k];
        neg_q[k] <= neg_in[k];
      end
    end
  end

  // restore sign, quotient truncates toward zero
  assign q_fin    = nq_q[SUM_W-1];
  assign q_signed = neg_q[SUM_W-1] ? SUM_W'(-q_fin) : q_fin;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv_o) begin
      out_valid_q <= v_q[SUM_W-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o) begin
      avg_q <= q_signed[SAMPLE_BITS-1:0];
    end
  end

  assign out_valid_o = out_valid_q;
  assign average_o   = $signed(avg_q);

  // partial remainder stays below the divisor, checked at first and last stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[0] |-> (r_q[0] < d_q[0]))
    else $error("first stage remainder not below divisor");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[SUM_W-1] |-> (r_q[SUM_W-1] < d_q[SUM_W-1]))
    else $error("last stage remainder not below divisor");

  // window length reaching the divider is never zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (div_valid_i && adv_o) |=> (d_q[0] != '0))
    else $error("zero divisor entered the pipe");

endmodule : mavg_div

`default_nettype wire

// File: src/moving_average_window_top.sv
// ----------------------------------------------------------------------------
// moving_average_window_top
// path: an input beat passes the ring read stage, the running sum register, the
//   one-bit-per-stage divider and its output register before its result beat
// throughput: one beat per cycle while the output is taken; a config write
//   starts a preload, during which no input beat is accepted
// reset: window length 8, init value 0, empty ring, no result pending
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module moving_average_window_top
  import mavg_pkg::*;
#(
  parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  // register write port
  input  wire                           cfg_we_i,
  input  wire  [CFG_IDX_W-1:0]          cfg_index_i,
  input  wire  [SAMPLE_BITS-1:0]        cfg_wdata_i,
  // sample beats in
  input  wire                           in_valid_i,
  output logic                          in_ready_o,
  input  wire  signed [SAMPLE_BITS-1:0] sample_i,
  // average beats out
  output logic                          out_valid_o,
  input  wire                           out_ready_i,
  output logic signed [SAMPLE_BITS-1:0] average_o
);

  localparam int LEN_W = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W = SAMPLE_BITS + $clog2(MAX_WINDOW);

  // front end to divider handoff
  logic                    adv;
  logic                    div_valid;
  logic signed [SUM_W-1:0] div_sum;
  logic [LEN_W-1:0]        div_len;

  // ring memory, pointer, fill count and running sum; the leaving sample is
  // read in the same cycle the new one is written, the sum is updated when
  // that beat advances, so back-to-back beats see no hazard on the ring
  mavg_front #(
    .MAX_WINDOW  (MAX_WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .sample_i    (sample_i),
    .adv_i       (adv),
    .div_valid_o (div_valid),
    .div_sum_o   (div_sum),
    .div_len_o   (div_len)
  );

  // sum divided by the effective window length, off the sum feedback loop;
  // the whole pipe holds while a finished beat waits in the output register
  mavg_div #(
    .MAX_WINDOW  (MAX_WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .div_valid_i (div_valid),
    .div_sum_i   (div_sum),
    .div_len_i   (div_len),
    .adv_o       (adv),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .average_o   (average_o)
  );

endmodule : moving_average_window_top

`default_nettype wire
